// File: sv/kvi_pkg.sv
package kvi_pkg;

  localparam int MAX_FRAMES_DEF   = 64;
  localparam int MAX_VERTS_DEF    = 512;
  localparam int MAX_MESH_IDS_DEF = 64;

  localparam int NORMAL_COUNT = 162;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  localparam logic [1:0] CMD_QUERY     = 2'd0;
  localparam logic [1:0] CMD_WR_FRAME  = 2'd1;
  localparam logic [1:0] CMD_WR_VERTEX = 2'd2;

  localparam logic [1:0] REG_MESH_ID     = 2'd0;
  localparam logic [1:0] REG_ANIMATED    = 2'd1;
  localparam logic [1:0] REG_FRAMES      = 2'd2;
  localparam logic [1:0] REG_VERTS       = 2'd3;

  localparam logic [15:0] QZ   = 16'd0;
  localparam logic [15:0] Q526 = 16'd8614;
  localparam logic [15:0] Q851 = 16'd13937;
  localparam logic [15:0] Q443 = 16'd7256;
  localparam logic [15:0] Q239 = 16'd3913;
  localparam logic [15:0] Q864 = 16'd14159;
  localparam logic [15:0] Q295 = 16'd4837;
  localparam logic [15:0] Q955 = 16'd15654;
  localparam logic [15:0] Q309 = 16'd5063;
  localparam logic [15:0] Q500 = 16'd8192;
  localparam logic [15:0] Q809 = 16'd13255;
  localparam logic [15:0] Q162 = 16'd2662;
  localparam logic [15:0] Q263 = 16'd4307;
  localparam logic [15:0] Q951 = 16'd15582;
  localparam logic [15:0] Q1   = 16'd16384;
  localparam logic [15:0] Q148 = 16'd2419;
  localparam logic [15:0] Q717 = 16'd11740;
  localparam logic [15:0] Q682 = 16'd11169;
  localparam logic [15:0] Q588 = 16'd9630;
  localparam logic [15:0] Q425 = 16'd6969;
  localparam logic [15:0] Q688 = 16'd11275;

  typedef logic [0:2][15:0] nvec_t;

  localparam nvec_t NORMALS [NORMAL_COUNT] = '{
    '{-Q526,QZ,Q851},'{-Q443,Q239,Q864},'{-Q295,QZ,Q955},'{-Q309,Q500,Q809},
    '{-Q162,Q263,Q951},'{QZ,QZ,Q1},'{QZ,Q851,Q526},'{-Q148,Q717,Q682},
    '{Q148,Q717,Q682},'{QZ,Q526,Q851},'{Q309,Q500,Q809},'{Q526,QZ,Q851},
    '{Q295,QZ,Q955},'{Q443,Q239,Q864},'{Q162,Q263,Q951},'{-Q682,Q148,Q717},
    '{-Q809,Q309,Q500},'{-Q588,Q425,Q688},'{-Q851,Q526,QZ},'{-Q864,Q443,Q239},
    '{-Q717,Q682,Q148},'{-Q688,Q588,Q425},'{-Q500,Q809,Q309},'{-Q239,Q864,Q443},
    '{-Q425,Q688,Q588},'{-Q717,Q682,-Q148},'{-Q500,Q809,-Q309},'{-Q526,Q851,QZ},
    '{QZ,Q851,-Q526},'{-Q239,Q864,-Q443},'{QZ,Q955,-Q295},'{-Q263,Q951,-Q162},
    '{QZ,Q1,QZ},'{QZ,Q955,Q295},'{-Q263,Q951,Q162},'{Q239,Q864,Q443},
    '{Q263,Q951,Q162},'{Q500,Q809,Q309},'{Q239,Q864,-Q443},'{Q263,Q951,-Q162},
    '{Q500,Q809,-Q309},'{Q851,Q526,QZ},'{Q717,Q682,Q148},'{Q717,Q682,-Q148},
    '{Q526,Q851,QZ},'{Q425,Q688,Q588},'{Q864,Q443,Q239},'{Q688,Q588,Q425},
    '{Q809,Q309,Q500},'{Q682,Q148,Q717},'{Q588,Q425,Q688},'{Q955,Q295,QZ},
    '{Q1,QZ,QZ},'{Q951,Q162,Q263},'{Q851,-Q526,QZ},'{Q955,-Q295,QZ},
    '{Q864,-Q443,Q239},'{Q951,-Q162,Q263},'{Q809,-Q309,Q500},'{Q682,-Q148,Q717},
    '{Q851,QZ,Q526},'{Q864,Q443,-Q239},'{Q809,Q309,-Q500},'{Q951,Q162,-Q263},
    '{Q526,QZ,-Q851},'{Q682,Q148,-Q717},'{Q682,-Q148,-Q717},'{Q851,QZ,-Q526},
    '{Q809,-Q309,-Q500},'{Q864,-Q443,-Q239},'{Q951,-Q162,-Q263},'{Q148,Q717,-Q682},
    '{Q309,Q500,-Q809},'{Q425,Q688,-Q588},'{Q443,Q239,-Q864},'{Q588,Q425,-Q688},
    '{Q688,Q588,-Q425},'{-Q148,Q717,-Q682},'{-Q309,Q500,-Q809},'{QZ,Q526,-Q851},
    '{-Q526,QZ,-Q851},'{-Q443,Q239,-Q864},'{-Q295,QZ,-Q955},'{-Q162,Q263,-Q951},
    '{QZ,QZ,-Q1},'{Q295,QZ,-Q955},'{Q162,Q263,-Q951},'{-Q443,-Q239,-Q864},
    '{-Q309,-Q500,-Q809},'{-Q162,-Q263,-Q951},'{QZ,-Q851,-Q526},'{-Q148,-Q717,-Q682},
    '{Q148,-Q717,-Q682},'{QZ,-Q526,-Q851},'{Q309,-Q500,-Q809},'{Q443,-Q239,-Q864},
    '{Q162,-Q263,-Q951},'{Q239,-Q864,-Q443},'{Q500,-Q809,-Q309},'{Q425,-Q688,-Q588},
    '{Q717,-Q682,-Q148},'{Q688,-Q588,-Q425},'{Q588,-Q425,-Q688},'{QZ,-Q955,-Q295},
    '{QZ,-Q1,QZ},'{Q263,-Q951,-Q162},'{QZ,-Q851,Q526},'{QZ,-Q955,Q295},
    '{Q239,-Q864,Q443},'{Q263,-Q951,Q162},'{Q500,-Q809,Q309},'{Q717,-Q682,Q148},
    '{Q526,-Q851,QZ},'{-Q239,-Q864,-Q443},'{-Q500,-Q809,-Q309},'{-Q263,-Q951,-Q162},
    '{-Q851,-Q526,QZ},'{-Q717,-Q682,-Q148},'{-Q717,-Q682,Q148},'{-Q526,-Q851,QZ},
    '{-Q500,-Q809,Q309},'{-Q239,-Q864,Q443},'{-Q263,-Q951,Q162},'{-Q864,-Q443,Q239},
    '{-Q809,-Q309,Q500},'{-Q688,-Q588,Q425},'{-Q682,-Q148,Q717},'{-Q443,-Q239,Q864},
    '{-Q588,-Q425,Q688},'{-Q309,-Q500,Q809},'{-Q148,-Q717,Q682},'{-Q425,-Q688,Q588},
    '{-Q162,-Q263,Q951},'{Q443,-Q239,Q864},'{Q162,-Q263,Q951},'{Q309,-Q500,Q809},
    '{Q148,-Q717,Q682},'{QZ,-Q526,Q851},'{Q425,-Q688,Q588},'{Q588,-Q425,Q688},
    '{Q688,-Q588,Q425},'{-Q955,Q295,QZ},'{-Q951,Q162,Q263},'{-Q1,QZ,QZ},
    '{-Q851,QZ,Q526},'{-Q955,-Q295,QZ},'{-Q951,-Q162,Q263},'{-Q864,Q443,-Q239},
    '{-Q951,Q162,-Q263},'{-Q809,Q309,-Q500},'{-Q864,-Q443,-Q239},'{-Q951,-Q162,-Q263},
    '{-Q809,-Q309,-Q500},'{-Q682,Q148,-Q717},'{-Q682,-Q148,-Q717},'{-Q851,QZ,-Q526},
    '{-Q688,Q588,-Q425},'{-Q588,Q425,-Q688},'{-Q425,Q688,-Q588},'{-Q425,-Q688,-Q588},
    '{-Q588,-Q425,-Q688},'{-Q688,-Q588,-Q425}
  };

  function automatic nvec_t normal_of(input logic [7:0] idx);
    logic [7:0] r;
    r = (idx >= 8'(NORMAL_COUNT)) ? idx - 8'(NORMAL_COUNT) : idx;
    return NORMALS[r];
  endfunction

endpackage

// File: sv/keyframe_vertex_interpolator.sv
// Keyframe vertex interpolator: holds one animated mesh (per-frame axis scale and offset,
// packed byte vertices) written by commands 1 and 2, and answers command 0 queries with a
// blended position and a renormalised normal. Fully pipelined: one transaction per cycle
// while out_ready_i does not stall the output; each one passes through 7 stages of table read,
// decompression and blending, 23 stages of square root, 16 stages of division and one
// output register, most of them in the square root and the three dividers. Writes take
// effect for every later transaction. Vertex and frame tables are kept in two copies, one
// per frame read port; their contents are undefined until written.
module keyframe_vertex_interpolator #(
  parameter int MAX_FRAMES   = kvi_pkg::MAX_FRAMES_DEF,
  parameter int MAX_VERTS    = kvi_pkg::MAX_VERTS_DEF,
  parameter int MAX_MESH_IDS = kvi_pkg::MAX_MESH_IDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [5:0]         mesh_number_i,
  input  logic [15:0]        first_frame_i,
  input  logic [15:0]        second_frame_i,
  input  logic [11:0]        vertex_number_i,
  input  logic [16:0]        blend_i,
  input  logic [1:0]         axis_i,
  input  logic signed [31:0] axis_scale_i,
  input  logic signed [31:0] axis_offset_i,
  input  logic [31:0]        packed_vertex_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic               query_valid_o
);

  localparam int FAW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int VTW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int VD  = MAX_FRAMES * MAX_VERTS;
  localparam int VAW = (VD > 1) ? $clog2(VD) : 1;
  localparam int RW  = 23;
  localparam int QW  = 16;
  localparam int L   = RW + QW;
  localparam int NST = 7 + L;

  localparam logic [1:0] KIND_HIT   = 2'd0;
  localparam logic [1:0] KIND_MISS  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [1:0]       kind;
    logic             zero;
    logic [2:0]       sgn;
    logic [2:0][14:0] mag;
  } side_t;

  logic [5:0] animated_mesh_id_q;
  logic       mesh_is_animated_q;
  logic [6:0] frames_in_use_q;
  logic [9:0] vertices_per_frame_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      animated_mesh_id_q   <= '0;
      mesh_is_animated_q   <= 1'b0;
      frames_in_use_q      <= 7'd1;
      vertices_per_frame_q <= 10'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        kvi_pkg::REG_MESH_ID:  animated_mesh_id_q   <= cfg_data_i[5:0];
        kvi_pkg::REG_ANIMATED: mesh_is_animated_q   <= cfg_data_i[0];
        kvi_pkg::REG_FRAMES:   frames_in_use_q      <= cfg_data_i[6:0];
        kvi_pkg::REG_VERTS:    vertices_per_frame_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv, acc;
  logic out_valid_q;
  logic vld_q [NST];

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && adv;

  // accept stage: decode, clamp, address
  logic [9:0]     fu, nfr;
  logic [12:0]    nv;
  logic [15:0]    fa_cl, fb_cl;
  logic [FAW-1:0] fa_idx, fb_idx, fw_idx;
  logic [VTW-1:0] vtx_idx;
  logic [VAW-1:0] va_addr, vb_addr, vw_addr;
  logic           hit, fwe, vwe;
  logic [1:0]     kind0;
  logic [16:0]    t0;

  always_comb begin
    fu  = (frames_in_use_q == 7'd0) ? 10'd1 : {3'd0, frames_in_use_q};
    nfr = (fu > 10'(MAX_FRAMES)) ? 10'(MAX_FRAMES) : fu;
    nv  = ({3'd0, vertices_per_frame_q} > 13'(MAX_VERTS)) ? 13'(MAX_VERTS)
                                                           : {3'd0, vertices_per_frame_q};
    fa_cl = (first_frame_i >= {6'd0, nfr}) ? {6'd0, nfr - 10'd1} : first_frame_i;
    fb_cl = (second_frame_i >= {6'd0, nfr}) ? {6'd0, nfr - 10'd1} : second_frame_i;
    fa_idx  = fa_cl[FAW-1:0];
    fb_idx  = fb_cl[FAW-1:0];
    fw_idx  = first_frame_i[FAW-1:0];
    vtx_idx = vertex_number_i[VTW-1:0];
    va_addr = VAW'(32'(fa_idx) * MAX_VERTS + 32'(vtx_idx));
    vb_addr = VAW'(32'(fb_idx) * MAX_VERTS + 32'(vtx_idx));
    vw_addr = VAW'(32'(fw_idx) * MAX_VERTS + 32'(vtx_idx));
    hit = mesh_is_animated_q && (mesh_number_i == animated_mesh_id_q)
       && ({5'd0, mesh_number_i} < 11'(MAX_MESH_IDS))
       && ({1'b0, vertex_number_i} < nv);
    fwe = acc && (command_i == kvi_pkg::CMD_WR_FRAME)
       && (first_frame_i < 16'(MAX_FRAMES)) && (axis_i != 2'd3);
    vwe = acc && (command_i == kvi_pkg::CMD_WR_VERTEX)
       && (first_frame_i < 16'(MAX_FRAMES)) && ({1'b0, vertex_number_i} < 13'(MAX_VERTS));
    priority case (command_i)
      kvi_pkg::CMD_QUERY:     kind0 = hit ? KIND_HIT : KIND_MISS;
      kvi_pkg::CMD_WR_FRAME,
      kvi_pkg::CMD_WR_VERTEX: kind0 = KIND_WRITE;
      default:                kind0 = KIND_NONE;
    endcase
    t0 = (blend_i > 17'h10000) ? 17'h10000 : blend_i;
  end

  logic [31:0] vmem_a [VD];
  logic [31:0] vmem_b [VD];
  logic [63:0] fmem_a [3][MAX_FRAMES];
  logic [63:0] fmem_b [3][MAX_FRAMES];

  logic [31:0] wa_q, wb_q;
  logic [63:0] fra_q [3];
  logic [63:0] frb_q [3];

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem_a[vw_addr] <= packed_vertex_i;
      vmem_b[vw_addr] <= packed_vertex_i;
    end
    for (int k = 0; k < 3; k++) begin
      if (fwe && axis_i == 2'(k)) begin
        fmem_a[k][fw_idx] <= {axis_scale_i, axis_offset_i};
        fmem_b[k][fw_idx] <= {axis_scale_i, axis_offset_i};
      end
    end
    if (adv) begin
      wa_q <= vmem_a[va_addr];
      wb_q <= vmem_b[vb_addr];
      for (int k = 0; k < 3; k++) begin
        fra_q[k] <= fmem_a[k][fa_idx];
        frb_q[k] <= fmem_b[k][fb_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  logic [1:0]  k1_q, k2_q, k3_q, k4_q, k5_q, k6_q, k7_q;
  logic [16:0] t1_q, t2_q, t3_q;
  logic signed [31:0] pa2_q [3];
  logic signed [31:0] pb2_q [3];
  logic signed [15:0] na2_q [3];
  logic signed [15:0] nb2_q [3];
  logic signed [32:0] dp3_q [3];
  logic signed [16:0] dn3_q [3];
  logic signed [31:0] pa3_q [3];
  logic signed [15:0] na3_q [3];
  logic signed [50:0] pr4_q [3];
  logic signed [34:0] nr4_q [3];
  logic signed [31:0] pa4_q [3];
  logic signed [15:0] na4_q [3];
  logic signed [31:0] pos5_q [3];
  logic signed [15:0] n5_q [3];
  logic [28:0]        sq6_q [3];
  logic signed [31:0] pos6_q [3];
  logic signed [15:0] n6_q [3];
  logic [29:0]        sum7_q;
  logic signed [31:0] pos7_q [3];
  logic signed [15:0] n7_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [40:0] m;
    logic signed [50:0] rp;
    logic signed [34:0] rn;
    logic signed [31:0] sq;
    kvi_pkg::nvec_t     va, vb;
    if (adv) begin
      k1_q <= kind0;
      t1_q <= t0;
      va = kvi_pkg::normal_of(wa_q[31:24]);
      vb = kvi_pkg::normal_of(wb_q[31:24]);
      k2_q <= k1_q;
      t2_q <= t1_q;
      k3_q <= k2_q;
      t3_q <= t2_q;
      k4_q <= k3_q;
      k5_q <= k4_q;
      k6_q <= k5_q;
      k7_q <= k6_q;
      for (int k = 0; k < 3; k++) begin
        m = $signed({1'b0, wa_q[8*k +: 8]}) * $signed(fra_q[k][63:32]);
        pa2_q[k] <= 32'(m + 41'($signed(fra_q[k][31:0])));
        m = $signed({1'b0, wb_q[8*k +: 8]}) * $signed(frb_q[k][63:32]);
        pb2_q[k] <= 32'(m + 41'($signed(frb_q[k][31:0])));
        na2_q[k] <= $signed(va[k]);
        nb2_q[k] <= $signed(vb[k]);

        dp3_q[k] <= 33'(pb2_q[k]) - 33'(pa2_q[k]);
        dn3_q[k] <= 17'(nb2_q[k]) - 17'(na2_q[k]);
        pa3_q[k] <= pa2_q[k];
        na3_q[k] <= na2_q[k];

        pr4_q[k] <= dp3_q[k] * $signed({1'b0, t3_q});
        nr4_q[k] <= dn3_q[k] * $signed({1'b0, t3_q});
        pa4_q[k] <= pa3_q[k];
        na4_q[k] <= na3_q[k];

        rp = (pr4_q[k] + 51'sd32768) >>> 16;
        rn = (nr4_q[k] + 35'sd32768) >>> 16;
        pos5_q[k] <= pa4_q[k] + rp[31:0];
        n5_q[k]   <= na4_q[k] + rn[15:0];

        sq = n5_q[k] * n5_q[k];
        sq6_q[k]  <= sq[28:0];
        pos6_q[k] <= pos5_q[k];
        n6_q[k]   <= n5_q[k];

        pos7_q[k] <= pos6_q[k];
        n7_q[k]   <= n6_q[k];
      end
      sum7_q <= 30'(sq6_q[0]) + 30'(sq6_q[1]) + 30'(sq6_q[2]);
    end
  end

  side_t side7, side_q [L];
  logic [RW-1:0] len;

  always_comb begin
    side7.kind = k7_q;
    side7.zero = (sum7_q == '0);
    for (int k = 0; k < 3; k++) begin
      side7.pos[k] = pos7_q[k];
      side7.sgn[k] = n7_q[k][15];
      side7.mag[k] = 15'(n7_q[k][15] ? -n7_q[k] : n7_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side7;
      for (int i = 1; i < L; i++) side_q[i] <= side_q[i-1];
    end
  end

  kvi_isqrt #(.VW(2 * RW)) u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .v_i    ({sum7_q, 16'd0}),
    .root_o (len)
  );

  logic [QW-1:0] quo [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    kvi_div #(.NW(RW + 16), .DW(RW + 1), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .n_i   ((RW + 16)'({side_q[RW-1].mag[k], 23'd0}) + (RW + 16)'(len)),
      .d_i   ({len, 1'b0}),
      .q_o   (quo[k])
    );
  end

  side_t sf;
  logic signed [31:0] pos_d [3];
  logic signed [15:0] nrm_d [3];
  logic               qv_d;

  always_comb begin
    logic [15:0] qc;
    sf = side_q[L-1];
    for (int k = 0; k < 3; k++) begin
      qc = (quo[k] > kvi_pkg::ONE_Q14) ? kvi_pkg::ONE_Q14 : quo[k];
      pos_d[k] = '0;
      nrm_d[k] = '0;
      unique case (sf.kind)
        KIND_HIT: begin
          pos_d[k] = sf.pos[k];
          if (sf.zero) nrm_d[k] = (k == 1) ? kvi_pkg::ONE_Q14 : '0;
          else         nrm_d[k] = sf.sgn[k] ? -qc : qc;
        end
        KIND_MISS: nrm_d[k] = (k == 1) ? kvi_pkg::ONE_Q14 : '0;
        default: ;
      endcase
    end
    qv_d = (sf.kind == KIND_HIT) || (sf.kind == KIND_WRITE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= vld_q[NST-1];
  end

  logic signed [31:0] pos_q [3];
  logic signed [15:0] nrm_q [3];
  logic               qv_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_q <= pos_d;
      nrm_q <= nrm_d;
      qv_q  <= qv_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pos_x_o       = pos_q[0];
  assign pos_y_o       = pos_q[1];
  assign pos_z_o       = pos_q[2];
  assign norm_x_o      = nrm_q[0];
  assign norm_y_o      = nrm_q[1];
  assign norm_z_o      = nrm_q[2];
  assign query_valid_o = qv_q;

`ifndef SYNTHESIS
  a_plain_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !query_valid_o |-> pos_x_o == '0 && pos_y_o == '0 && pos_z_o == '0)
    else $error("missed or unknown transaction carries a position");
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> norm_x_o <= 16'sd16384 && norm_x_o >= -16'sd16384
                 && norm_y_o <= 16'sd16384 && norm_y_o >= -16'sd16384
                 && norm_z_o <= 16'sd16384 && norm_z_o >= -16'sd16384)
    else $error("normal component outside unit range");
  a_axis_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && query_valid_o && norm_x_o == '0 && norm_z_o == '0 && norm_y_o != '0
      |-> norm_y_o == 16'sd16384 || norm_y_o == -16'sd16384)
    else $error("axis-aligned normal not of unit length");
`endif

endmodule

// File: sv/kvi_isqrt.sv
module kvi_isqrt #(
  parameter int VW = 46
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [VW-1:0]      v_i,
  output logic [VW/2-1:0]    root_o
);

  localparam int RW = VW / 2;

  logic [RW+1:0] rem_q  [RW];
  logic [RW+1:0] rem_d  [RW];
  logic [RW-1:0] root_q [RW];
  logic [RW-1:0] root_d [RW];
  logic [VW-1:0] rest_q [RW];
  logic [VW-1:0] rest_d [RW];

  always_comb begin
    logic [RW+1:0] rp;
    logic [RW-1:0] tp;
    logic [VW-1:0] sp;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    for (int i = 0; i < RW; i++) begin
      if (i == 0) begin
        rp = '0;
        tp = '0;
        sp = v_i;
      end else begin
        rp = rem_q[i-1];
        tp = root_q[i-1];
        sp = rest_q[i-1];
      end
      cur   = {rp[RW-1:0], sp[VW-1:VW-2]};
      trial = {tp, 2'b01};
      if (cur >= trial) begin
        rem_d[i]  = cur - trial;
        root_d[i] = {tp[RW-2:0], 1'b1};
      end else begin
        rem_d[i]  = cur;
        root_d[i] = {tp[RW-2:0], 1'b0};
      end
      rest_d[i] = {sp[VW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rest_q <= rest_d;
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// File: sv/kvi_div.sv
module kvi_div #(
  parameter int NW = 39,
  parameter int DW = 24,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] rem_d  [QW];
  logic [DW-1:0] dv_q   [QW];
  logic [DW-1:0] dv_d   [QW];
  logic [QW-1:0] rest_q [QW];
  logic [QW-1:0] rest_d [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [QW-1:0] quo_d  [QW];

  always_comb begin
    logic [DW-1:0] rp;
    logic [DW-1:0] dp;
    logic [QW-1:0] sp;
    logic [QW-1:0] qp;
    logic [DW:0]   cur;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rp = DW'(n_i[NW-1:QW]);
        dp = d_i;
        sp = n_i[QW-1:0];
        qp = '0;
      end else begin
        rp = rem_q[i-1];
        dp = dv_q[i-1];
        sp = rest_q[i-1];
        qp = quo_q[i-1];
      end
      cur = {rp, sp[QW-1]};
      if (cur >= {1'b0, dp}) begin
        rem_d[i] = DW'(cur - {1'b0, dp});
        quo_d[i] = {qp[QW-2:0], 1'b1};
      end else begin
        rem_d[i] = cur[DW-1:0];
        quo_d[i] = {qp[QW-2:0], 1'b0};
      end
      dv_d[i]   = dp;
      rest_d[i] = {sp[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      dv_q   <= dv_d;
      rest_q <= rest_d;
      quo_q  <= quo_d;
    end
  end

  assign q_o = quo_q[QW-1];

endmodule
